/* sv/wbp_pkg.sv */
// Shared types, constants and helpers for the wall bounce pressure block.
package wbp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int REST_BITS     = 14;
  localparam int P_W           = 48;
  localparam int MAG_W         = 49;
  localparam logic [P_W-1:0] P_MAX = {P_W{1'b1}};

  typedef struct packed {
    logic               frame_start;
    logic signed [31:0] pos_normal;
    logic signed [31:0] vel_normal;
    logic [14:0]        radius;
    logic [15:0]        restitution;
    logic [15:0]        mass;
    logic               wall_is_max;
    logic               wall_axis;
    logic signed [15:0] wall_pos;
    logic signed [31:0] wall_vel;
    logic [15:0]        wall_len;
    logic [31:0]        time_step;
  } item_t;

  typedef struct packed {
    logic               bounced;
    logic               axis_out;
    logic signed [31:0] new_pos;
    logic signed [31:0] new_vel;
    logic [P_W-1:0]     pressure_total;
  } result_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic div_step;
    logic accum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic div_last;
    logic out_free;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/wbp_item_if.sv */
// Input channel carrying one particle-wall pair.
interface wbp_item_if import wbp_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* sv/wbp_result_if.sv */
// Output channel carrying one collision result.
interface wbp_result_if import wbp_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* sv/wbp_ctrl.sv */
// Sequencing state machine for the wall bounce pressure block.
module wbp_ctrl import wbp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL1  = 7'b0000010,
    S_MUL2  = 7'b0000100,
    S_MUL3  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_ACC   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = status.skip ? S_ACC : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accum  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/wbp_dpath.sv */
// Datapath: limit, bounce test, velocity and pressure arithmetic, divider, sum.
module wbp_dpath import wbp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  item_t        item_data,
  input  cmd_t         cmd,
  output status_t      status,
  wbp_result_if.source result
);

  localparam int LIM_W  = 18 + FRAC_BITS;
  localparam int EXT_W  = ((LIM_W > 32) ? LIM_W : 32) + 2;
  localparam int DIVD_W = MAG_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(DIVD_W + 1);

  logic signed [31:0] pos, vel, wvel, npos, nvel;
  logic [15:0]        rest, mass, wlen;
  logic               is_max, axis, bounce;
  logic [31:0]        tstep;
  logic signed [LIM_W-1:0] limit;
  logic signed [48:0] prod;
  logic [P_W-1:0]     dvsr;
  logic [DIVD_W-1:0]  quo;
  logic [P_W-1:0]     rem;
  logic [CNT_W-1:0]   cnt;
  logic [P_W-1:0]     sum;
  logic               out_valid;
  result_t            out_data;

  logic signed [17:0]      base;
  logic signed [EXT_W-1:0] pos_x, lim_x, npos_x;
  logic signed [32:0]      dv;
  logic [32:0]             absdv;
  logic [MAG_W-1:0]        mag;
  logic [P_W:0]            rem_sh;
  logic                    ge;
  logic [P_W-1:0]          pval;
  logic [P_W:0]            sum_add;

  always_comb begin
    base    = item_data.wall_is_max
            ? ($signed({{2{item_data.wall_pos[15]}}, item_data.wall_pos})
               - $signed({3'b000, item_data.radius}))
            : ($signed({{2{item_data.wall_pos[15]}}, item_data.wall_pos})
               + $signed({3'b000, item_data.radius}));
    pos_x   = EXT_W'(pos);
    lim_x   = EXT_W'(limit);
    npos_x  = (lim_x <<< 1) - pos_x;
    dv      = $signed({nvel[31], nvel}) - $signed({vel[31], vel});
    absdv   = dv[32] ? 33'(-dv) : 33'(dv);
    mag     = MAG_W'(mass) * MAG_W'(absdv);
    rem_sh  = {rem, quo[DIVD_W-1]};
    ge      = rem_sh >= {1'b0, dvsr};
    pval    = status.skip ? '0
            : ((|quo[DIVD_W-1:P_W]) ? P_MAX : quo[P_W-1:0]);
    sum_add = {1'b0, sum} + {1'b0, pval};
  end

  assign status.skip     = !bounce || (tstep == '0);
  assign status.div_last = (cnt == CNT_W'(1));
  assign status.out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos    <= item_data.pos_normal;
      vel    <= item_data.vel_normal;
      rest   <= item_data.restitution;
      mass   <= item_data.mass;
      is_max <= item_data.wall_is_max;
      axis   <= item_data.wall_axis;
      wvel   <= item_data.wall_vel;
      wlen   <= item_data.wall_len;
      tstep  <= item_data.time_step;
      limit  <= {base, {FRAC_BITS{1'b0}}};
    end
    if (cmd.mul1) begin
      bounce <= (wlen != '0) && (is_max ? (pos_x >= lim_x) : (pos_x <= lim_x));
      npos   <= sat32(64'(npos_x));
      prod   <= $signed(49'($signed({1'b0, rest}))) * $signed(49'(vel));
      dvsr   <= P_W'(tstep) * P_W'(wlen);
    end
    if (cmd.mul2) begin
      nvel <= sat32(64'(wvel) - 64'(prod >>> REST_BITS));
    end
    if (cmd.mul3) begin
      quo <= {mag, {FRAC_BITS{1'b0}}};
      rem <= '0;
      cnt <= CNT_W'(DIVD_W);
    end
    if (cmd.div_step) begin
      rem <= ge ? P_W'(rem_sh - {1'b0, dvsr}) : rem_sh[P_W-1:0];
      quo <= {quo[DIVD_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.emit) begin
      out_data.bounced        <= bounce;
      out_data.axis_out       <= axis;
      out_data.new_pos        <= bounce ? npos : pos;
      out_data.new_vel        <= bounce ? nvel : vel;
      out_data.pressure_total <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load && item_data.frame_start) begin
        sum <= '0;
      end else if (cmd.accum) begin
        sum <= sum_add[P_W] ? P_MAX : sum_add[P_W-1:0];
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

/* sv/wall_bounce_pressure.sv */
// Top level: one particle-wall collision per transfer, with per-frame pressure sum.
// A bounce with nonzero time step runs the divider, one quotient bit a cycle; other pairs
// skip the divider and add nothing to the pressure sum.
// One pair at a time, the next taken only once the last is emitted; a held result stalls it.
// Reset: synchronous rst clears the sequencer, the output valid and the pressure sum.
module wall_bounce_pressure import wbp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  wbp_item_if.sink     item,
  wbp_result_if.source result
);

  cmd_t    cmd;
  status_t status;

  wbp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  wbp_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item_data (item.data),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

/* tb/sv/tb_wall_bounce_pressure.sv */
// Testbench for wall_bounce_pressure: random and directed pairs, scoreboard check.
module tb_wall_bounce_pressure import wbp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1030;
  localparam int LONG_HOLD  = 400;

  class bounce_scoreboard;
    logic [P_W-1:0] pressure_sum;
    result_t        expected_q[$];
    int             errors;

    function new();
      pressure_sum = '0;
      errors       = 0;
    endfunction

    function logic signed [31:0] clamp_q32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
    endfunction

    function void note_pair(input item_t it);
      logic signed [63:0] wp, rd, lim, ps, vl, wv, rs, np, nv, dv;
      logic [63:0]        mag, den, adv;
      logic [127:0]       num, quo;
      logic [P_W:0]       acc;
      logic [P_W-1:0]     p;
      logic               hit;
      result_t            r;
      wp  = 64'(it.wall_pos);
      rd  = {49'b0, it.radius};
      ps  = 64'(it.pos_normal);
      vl  = 64'(it.vel_normal);
      wv  = 64'(it.wall_vel);
      rs  = {48'b0, it.restitution};
      if (it.frame_start) pressure_sum = '0;
      lim = (it.wall_is_max ? wp - rd : wp + rd) * 64'sd65536;
      hit = (it.wall_len != 0) && (it.wall_is_max ? ps >= lim : ps <= lim);
      np  = ps;
      nv  = vl;
      if (hit) begin
        np  = clamp_q32(2 * lim - ps);
        nv  = clamp_q32(wv - ((rs * vl) >>> REST_BITS));
        dv  = nv - vl;
        adv = (dv < 0) ? -dv : dv;
        mag = {48'b0, it.mass} * adv;
        den = {32'b0, it.time_step} * {48'b0, it.wall_len};
        p   = '0;
        if (den != 0) begin
          num = {64'b0, mag} << FRAC_BITS_DEF;
          quo = num / {64'b0, den};
          p   = (quo > {80'b0, P_MAX}) ? P_MAX : quo[P_W-1:0];
        end
        acc = {1'b0, pressure_sum} + {1'b0, p};
        pressure_sum = acc[P_W] ? P_MAX : acc[P_W-1:0];
      end
      r.bounced        = hit;
      r.axis_out       = it.wall_axis;
      r.new_pos        = np[31:0];
      r.new_vel        = nv[31:0];
      r.pressure_total = pressure_sum;
      expected_q.push_back(r);
    endfunction

    function void check_result(input result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.bounced !== e.bounced) begin
        $error("bounced: expected %0d actual %0d", e.bounced, got.bounced);
        errors++;
      end
      if (got.axis_out !== e.axis_out) begin
        $error("axis_out: expected %0d actual %0d", e.axis_out, got.axis_out);
        errors++;
      end
      if (got.new_pos !== e.new_pos) begin
        $error("new_pos: expected %0d actual %0d", e.new_pos, got.new_pos);
        errors++;
      end
      if (got.new_vel !== e.new_vel) begin
        $error("new_vel: expected %0d actual %0d", e.new_vel, got.new_vel);
        errors++;
      end
      if (got.pressure_total !== e.pressure_total) begin
        $error("pressure_total: expected %0h actual %0h", e.pressure_total,
               got.pressure_total);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  wbp_item_if   item();
  wbp_result_if result();
  bounce_scoreboard sb;
  bit long_hold_req;

  wall_bounce_pressure u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    sb = new();
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) sb.check_result(result.data);
  end

  function automatic item_t random_pair();
    item_t it;
    int    mode;
    it.frame_start = ($urandom_range(0, 7) == 0);
    it.wall_axis   = 1'($urandom);
    it.wall_is_max = 1'($urandom);
    it.mass        = 16'($urandom);
    it.restitution = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                     : 16'($urandom_range(0, 16384));
    it.wall_len    = ($urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom);
    mode           = $urandom_range(0, 9);
    if (mode < 2) begin
      it.radius     = 15'($urandom);
      it.wall_pos   = 16'($urandom);
      it.pos_normal = 32'($urandom);
      it.vel_normal = 32'($urandom);
      it.wall_vel   = 32'($urandom);
    end else begin
      it.radius     = ($urandom_range(0, 7) == 0) ? 15'($urandom)
                      : 15'($urandom_range(0, 20));
      it.wall_pos   = $signed(16'($urandom_range(0, 400))) - 16'sd200;
      it.pos_normal = (32'(it.wall_pos) + (it.wall_is_max ? -$signed({17'b0, it.radius})
                       : $signed({17'b0, it.radius}))) * 65536
                      + $signed(32'($urandom_range(0, 1 << 20))) - 32'sd524288;
      it.vel_normal = $signed(32'($urandom_range(0, 1 << 22))) - 32'sd2097152;
      it.wall_vel   = ($urandom_range(0, 3) == 0) ? 32'($urandom)
                      : $signed(32'($urandom_range(0, 1 << 18))) - 32'sd131072;
    end
    case ($urandom_range(0, 5))
      0: it.time_step = 32'd0;
      1: it.time_step = $urandom_range(1, 16);
      2: it.time_step = $urandom;
      default: it.time_step = $urandom_range(1 << 12, 1 << 18);
    endcase
    return it;
  endfunction

  task automatic send_pair(input item_t it);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    if (gap != 0 && item.valid) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else if (gap != 0) begin
      repeat (gap) @(posedge clk);
    end
    item.valid <= 1'b1;
    item.data  <= it;
    do @(posedge clk); while (!item.ready);
    sb.note_pair(it);
  endtask

  task automatic drain_results();
    if (item.valid) item.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, runs with no stall, one long hold-off on request
  initial begin
    int n;
    int calm;
    result.ready = 1'b0;
    calm = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        result.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end
      if (calm == 0 && $urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
      n = (calm != 0) ? 0 : $urandom_range(0, 17);
      if (calm != 0) calm--;
      if (n != 0) begin
        result.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!(result.valid && result.ready));
    end
  end

  initial begin
    item_t base;
    item_t it;
    item.valid = 1'b0;
    item.data  = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    base = '0;
    base.mass = 16'd10;
    base.restitution = 16'd16384;
    base.wall_len = 16'd1;
    base.time_step = 32'h0001_0000;
    base.vel_normal = -32'sh0002_0000;
    // min wall hit, exactly at limit, just outside
    it = base; it.frame_start = 1'b1; it.pos_normal = -32'sh0001_0000; send_pair(it);
    it = base; it.pos_normal = 32'sh0; send_pair(it);
    it = base; it.pos_normal = 32'sh1; send_pair(it);
    // max wall hit and at limit
    it = base; it.wall_is_max = 1'b1; it.wall_axis = 1'b1; it.pos_normal = 32'sh1;
    send_pair(it);
    it = base; it.wall_is_max = 1'b1; it.pos_normal = 32'sh0; it.wall_pos = 16'sd0; send_pair(it);
    // disabled wall, zero time step
    it = base; it.wall_len = 16'd0; it.pos_normal = 32'sh80000000; send_pair(it);
    it = base; it.time_step = 32'd0; it.pos_normal = -32'sh10; send_pair(it);
    // position and velocity saturation, pressure saturation
    it = base; it.wall_pos = 16'sh7FFF; it.radius = 15'h7FFF; it.pos_normal = 32'sh80000000;
    it.vel_normal = 32'sh80000000; it.restitution = 16'hFFFF; it.wall_vel = 32'sh7FFFFFFF;
    it.mass = 16'hFFFF; it.time_step = 32'd1; send_pair(it);
    it.wall_is_max = 1'b1; it.wall_pos = 16'sh8000; it.pos_normal = 32'sh7FFFFFFF;
    it.vel_normal = 32'sh7FFFFFFF; it.wall_vel = 32'sh80000000; send_pair(it);
    send_pair(it);
    it.time_step = 32'hFFFFFFFF; it.wall_len = 16'hFFFF; it.mass = 16'd1; send_pair(it);
    it = base; it.frame_start = 1'b1; it.mass = 16'd0; it.pos_normal = -32'sh5; send_pair(it);
    it = base; it.vel_normal = 32'sh3; it.restitution = 16'd8191; it.pos_normal = -32'sh5;
    send_pair(it);
    drain_results();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 300) long_hold_req = 1'b1;
      if (i == 600) drain_results();
      send_pair(random_pair());
    end
    drain_results();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
